### hdl/oqr_pkg.sv
package oqr_pkg;

    // Field widths of one queue entry, and the width of the entry total
    localparam int ID_W   = 8;
    localparam int DATA_W = 32;
    localparam int TOTAL_W = 5;

    // Request kinds
    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    // One stored entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
    } t_entry;

    // Memory port enables from controller to store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

### hdl/oqr_store.sv
module oqr_store import oqr_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/oqr_ctrl.sv
module oqr_ctrl import oqr_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [ID_W-1:0]    i_player_id,
    input  logic [DATA_W-1:0]  i_player_data,
    output t_mem_ctl           o_mem_ctl,
    output logic [AW-1:0]      o_waddr,
    output t_entry             o_wdata,
    output logic [AW-1:0]      o_raddr,
    input  t_entry             i_rdata,
    output logic               o_result_valid,
    output logic               o_head_valid,
    output logic [ID_W-1:0]    o_head_id,
    output logic [DATA_W-1:0]  o_head_data,
    output logic               o_queue_empty,
    output logic [TOTAL_W-1:0] o_entry_total,
    output logic [1:0]         o_status
);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    t_entry            r_head, n_head;
    logic [ID_W-1:0]   r_id, n_id;
    logic [CW-1:0]     r_rd_addr, n_rd_addr;
    logic              r_rt_vld, n_rt_vld;
    logic [AW-1:0]     r_rt_idx, n_rt_idx;
    logic              r_found, n_found;

    logic              r_out_valid, n_out_valid;
    logic              r_out_head_valid, n_out_head_valid;
    t_entry            r_out_head, n_out_head;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    t_status           r_out_status, n_out_status;

    logic              rd_more;
    logic              last;
    logic              match;
    logic              finish;
    t_status           fin_status;
    logic [CW+TOTAL_W-1:0] count_wide;

    // Walk status
    assign rd_more = (r_rd_addr < r_count);
    assign last    = r_rt_vld && (CW'(r_rt_idx) == (r_count - CW'(1)));
    assign match   = r_rt_vld && !r_found && (i_rdata.id == r_id);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && (i_kind == KIND_REMOVE) && (r_count != '0)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_count          = r_count;
        n_head           = r_head;
        n_id             = r_id;
        n_rd_addr        = r_rd_addr;
        n_rt_vld         = 1'b0;
        n_rt_idx         = r_rt_idx;
        n_found          = r_found;
        o_mem_ctl        = '0;
        o_waddr          = r_count[AW-1:0];
        o_wdata          = '{id: i_player_id, data: i_player_data};
        o_raddr          = r_rd_addr[AW-1:0];
        finish           = 1'b0;
        fin_status       = ST_DONE;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_kind == KIND_APPEND) begin
                        finish = 1'b1;
                        if (r_count == CW'(DEPTH)) begin
                            fin_status = ST_FULL;
                        end else begin
                            // Store at the tail, track the head copy
                            o_mem_ctl.wr_en = 1'b1;
                            if (r_count == '0) begin
                                n_head = o_wdata;
                            end
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        finish     = 1'b1;
                        fin_status = ST_NOT_FOUND;
                    end else begin
                        // Begin walk from the head
                        n_id      = i_player_id;
                        n_rd_addr = '0;
                        n_found   = 1'b0;
                    end
                end
            end
            S_WALK: begin
                // Issue the next read
                if (rd_more) begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_rd_addr       = r_rd_addr + CW'(1);
                end
                n_rt_vld = rd_more;
                n_rt_idx = r_rd_addr[AW-1:0];
                // Handle the returned entry: search, or shift down one slot
                if (r_rt_vld) begin
                    if (r_found) begin
                        o_mem_ctl.wr_en = 1'b1;
                        o_waddr         = r_rt_idx - AW'(1);
                        o_wdata         = i_rdata;
                        if (r_rt_idx == AW'(1)) begin
                            n_head = i_rdata;
                        end
                    end else if (match) begin
                        n_found = 1'b1;
                    end
                end
                if (last) begin
                    finish = 1'b1;
                    if (r_found || match) begin
                        n_count = r_count - CW'(1);
                    end else begin
                        fin_status = ST_NOT_FOUND;
                    end
                end
            end
            default: ;
        endcase
    end

    // Build the result
    assign count_wide = {{TOTAL_W{1'b0}}, n_count};

    always_comb begin
        n_out_valid      = finish;
        n_out_head_valid = r_out_head_valid;
        n_out_head       = r_out_head;
        n_out_total      = r_out_total;
        n_out_status     = r_out_status;
        if (finish) begin
            n_out_head_valid = (n_count != '0);
            n_out_head       = (n_count != '0) ? n_head : '0;
            n_out_total      = count_wide[TOTAL_W-1:0];
            n_out_status     = fin_status;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rt_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rt_vld    <= n_rt_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_head           <= n_head;
        r_id             <= n_id;
        r_rd_addr        <= n_rd_addr;
        r_rt_idx         <= n_rt_idx;
        r_found          <= n_found;
        r_out_head_valid <= n_out_head_valid;
        r_out_head       <= n_out_head;
        r_out_total      <= n_out_total;
        r_out_status     <= n_out_status;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_head_valid   = r_out_head_valid;
    assign o_head_id      = r_out_head.id;
    assign o_head_data    = r_out_head.data;
    assign o_queue_empty  = !r_out_head_valid;
    assign o_entry_total  = r_out_total;
    assign o_status       = r_out_status;

endmodule

### hdl/ordered_queue_remove_by_id_unit.sv
// Channel   Handshake                      Payload
// request   start / busy (accept: start & !busy)  i_kind, i_player_id, i_player_data
// result    o_result_valid (one-cycle strobe)     o_head_valid, o_head_id, o_head_data,
//                                                 o_queue_empty, o_entry_total, o_status
//
// Append and rejected requests finish in the accept cycle: the result strobes the cycle after accept.
// A remove walks the entry memory through its single read port, one entry per cycle,
// and shifts later entries down through the write port behind the read: busy stays
// high until the last entry returns, and the result strobes in the first cycle busy is low.
// Reset is synchronous and active low; it empties the queue without touching memory.
// The receiver cannot stall; a new request may be accepted while a result strobes.
module ordered_queue_remove_by_id_unit import oqr_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [ID_W-1:0]    i_player_id,
    input  logic [DATA_W-1:0]  i_player_data,
    output logic               o_result_valid,
    output logic               o_head_valid,
    output logic [ID_W-1:0]    o_head_id,
    output logic [DATA_W-1:0]  o_head_data,
    output logic               o_queue_empty,
    output logic [TOTAL_W-1:0] o_entry_total,
    output logic [1:0]         o_status
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW+TOTAL_W-1:0] FULL_WIDE = (CW+TOTAL_W)'(QUEUE_DEPTH);
    localparam logic [TOTAL_W-1:0] FULL_TOTAL = FULL_WIDE[TOTAL_W-1:0];

    t_mem_ctl      mem_ctl;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    t_entry        wdata;
    t_entry        rdata;

    // Entry memory
    oqr_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Request sequencer
    oqr_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_player_id    (i_player_id),
        .i_player_data  (i_player_data),
        .o_mem_ctl      (mem_ctl),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_result_valid (o_result_valid),
        .o_head_valid   (o_head_valid),
        .o_head_id      (o_head_id),
        .o_head_data    (o_head_data),
        .o_queue_empty  (o_queue_empty),
        .o_entry_total  (o_entry_total),
        .o_status       (o_status)
    );

    // An accepted request either finishes next cycle or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_result_valid || busy))
        else $error("accepted request neither finished nor busy");

    // A result never strobes while a remove walk is running
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobed during walk");

    // An empty queue reports a zero head
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_queue_empty) |-> (o_head_id == '0 && o_head_data == '0))
        else $error("empty queue with nonzero head");

    // A dropped append reports a full queue
    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_FULL) |-> (o_entry_total == FULL_TOTAL))
        else $error("full status with wrong entry total");

endmodule

### tb/sv/oqr_head_checker.sv
`timescale 1ns / 1ps

module oqr_head_checker import oqr_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_kind,
    input  logic [ID_W-1:0]    i_player_id,
    input  logic [DATA_W-1:0]  i_player_data,
    input  logic               o_result_valid,
    input  logic               o_head_valid,
    input  logic [ID_W-1:0]    o_head_id,
    input  logic [DATA_W-1:0]  o_head_data,
    input  logic               o_queue_empty,
    input  logic [TOTAL_W-1:0] o_entry_total,
    input  logic [1:0]         o_status,
    output int                 fail_count,
    output int                 outstanding
);

    // Head view that one request leaves behind
    typedef struct {
        logic               head_valid;
        logic [ID_W-1:0]    head_id;
        logic [DATA_W-1:0]  head_data;
        logic               queue_empty;
        logic [TOTAL_W-1:0] entry_total;
        t_status            status;
    } t_head_view;

    // Shadow copy of the ordered store, head at slot 0
    logic [ID_W-1:0]   shadow_ids  [QUEUE_DEPTH];
    logic [DATA_W-1:0] shadow_data [QUEUE_DEPTH];
    int                shadow_fill;

    t_head_view pending_heads[$];

    // Apply one request to the shadow store and return the head it leaves
    function automatic t_head_view apply_request(input logic kind,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [DATA_W-1:0] data);
        t_head_view view;
        int pos;
        int k;
        bit hit;
        view.status = ST_DONE;
        if (kind == KIND_APPEND) begin
            if (shadow_fill >= QUEUE_DEPTH) begin
                view.status = ST_FULL;
            end else begin
                shadow_ids[shadow_fill]  = id;
                shadow_data[shadow_fill] = data;
                shadow_fill++;
            end
        end else begin
            // Find the match nearest the head
            hit = 1'b0;
            pos = 0;
            while (pos < shadow_fill && !hit) begin
                if (shadow_ids[pos] == id) begin
                    hit = 1'b1;
                end else begin
                    pos++;
                end
            end
            if (hit) begin
                // Close the gap, keep order
                for (k = pos; k + 1 < shadow_fill; k++) begin
                    shadow_ids[k]  = shadow_ids[k+1];
                    shadow_data[k] = shadow_data[k+1];
                end
                shadow_fill--;
            end else begin
                view.status = ST_NOT_FOUND;
            end
        end
        if (shadow_fill > 0) begin
            view.head_valid  = 1'b1;
            view.head_id     = shadow_ids[0];
            view.head_data   = shadow_data[0];
            view.queue_empty = 1'b0;
        end else begin
            view.head_valid  = 1'b0;
            view.head_id     = '0;
            view.head_data   = '0;
            view.queue_empty = 1'b1;
        end
        view.entry_total = TOTAL_W'(shadow_fill);
        return view;
    endfunction

    // Check results against the oldest prediction, then record new requests
    always @(posedge i_clk) begin : watch
        t_head_view want;
        int errs;
        int popped;
        int pushed;
        errs   = 0;
        popped = 0;
        pushed = 0;
        if (!i_rst_n) begin
            shadow_fill = 0;
            pending_heads.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end else begin
            if (o_result_valid) begin
                if (pending_heads.size() == 0) begin
                    $error("result strobe with no request pending");
                    errs++;
                end else begin
                    want   = pending_heads.pop_front();
                    popped = 1;
                    if (o_head_valid !== want.head_valid) begin
                        $error("head_valid: expected %0d, got %0d",
                               want.head_valid, o_head_valid);
                        errs++;
                    end
                    if (o_head_id !== want.head_id) begin
                        $error("head_id: expected %0d, got %0d", want.head_id, o_head_id);
                        errs++;
                    end
                    if (o_head_data !== want.head_data) begin
                        $error("head_data: expected 0x%08h, got 0x%08h",
                               want.head_data, o_head_data);
                        errs++;
                    end
                    if (o_queue_empty !== want.queue_empty) begin
                        $error("queue_empty: expected %0d, got %0d",
                               want.queue_empty, o_queue_empty);
                        errs++;
                    end
                    if (o_entry_total !== want.entry_total) begin
                        $error("entry_total: expected %0d, got %0d",
                               want.entry_total, o_entry_total);
                        errs++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        errs++;
                    end
                end
            end
            if (start && !busy) begin
                pending_heads.push_back(apply_request(i_kind, i_player_id, i_player_data));
                pushed = 1;
            end
            fail_count  <= fail_count + errs;
            outstanding <= outstanding + pushed - popped;
        end
    end

endmodule

### tb/sv/tb_ordered_queue_remove_by_id_unit.sv
`timescale 1ns / 1ps

module tb_ordered_queue_remove_by_id_unit;
    import oqr_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int PHASE_ITEMS = 450;
    localparam int DRAIN_CYCLES = 3 * QUEUE_DEPTH + 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_kind;
    logic [ID_W-1:0]    i_player_id;
    logic [DATA_W-1:0]  i_player_data;
    logic               o_result_valid;
    logic               o_head_valid;
    logic [ID_W-1:0]    o_head_id;
    logic [DATA_W-1:0]  o_head_data;
    logic               o_queue_empty;
    logic [TOTAL_W-1:0] o_entry_total;
    logic [1:0]         o_status;

    int fail_count;
    int outstanding;
    int sender_idle_pct;

    ordered_queue_remove_by_id_unit #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_player_id    (i_player_id),
        .i_player_data  (i_player_data),
        .o_result_valid (o_result_valid),
        .o_head_valid   (o_head_valid),
        .o_head_id      (o_head_id),
        .o_head_data    (o_head_data),
        .o_queue_empty  (o_queue_empty),
        .o_entry_total  (o_entry_total),
        .o_status       (o_status)
    );

    oqr_head_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_head_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_player_id    (i_player_id),
        .i_player_data  (i_player_data),
        .o_result_valid (o_result_valid),
        .o_head_valid   (o_head_valid),
        .o_head_id      (o_head_id),
        .o_head_data    (o_head_data),
        .o_queue_empty  (o_queue_empty),
        .o_entry_total  (o_entry_total),
        .o_status       (o_status),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Hold off at random, then present one request until it is taken
    task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
                                input logic [DATA_W-1:0] data);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= kind;
        i_player_id   <= id;
        i_player_data <= data;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Stop sending until every predicted result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random traffic with a fill bias that wanders between segments
    task automatic random_phase(input int count);
        int append_pct;
        logic kind;
        logic [ID_W-1:0] id;
        logic [DATA_W-1:0] data;
        append_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: append_pct = 15;
                    1: append_pct = 50;
                    default: append_pct = 85;
                endcase
            end
            kind = ($urandom_range(0, 99) < append_pct) ? KIND_APPEND : KIND_REMOVE;
            // Keep most ids in a small pool so removes hit and duplicates occur
            if ($urandom_range(0, 3) == 0) begin
                id = ID_W'($urandom_range(0, 255));
            end else begin
                id = ID_W'($urandom_range(0, 11));
            end
            case ($urandom_range(0, 9))
                0: data = '0;
                1: data = '1;
                default: data = $urandom;
            endcase
            send_request(kind, id, data);
        end
    endtask

    // Reset, directed corners, four random phases, drain and verdict
    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_kind          = KIND_APPEND;
        i_player_id     = '0;
        i_player_data   = '0;
        sender_idle_pct = 28;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Remove on an empty queue
        send_request(KIND_REMOVE, 8'd0, 32'h0);
        // Extremes and a duplicate id
        send_request(KIND_APPEND, 8'd0, 32'h0000_0000);
        send_request(KIND_APPEND, 8'd255, 32'hFFFF_FFFF);
        send_request(KIND_APPEND, 8'd0, 32'hA5A5_5A5A);
        // Duplicate: the one nearest the head goes first
        send_request(KIND_REMOVE, 8'd0, 32'h1234_5678);
        send_request(KIND_REMOVE, 8'd0, 32'h0);
        send_request(KIND_REMOVE, 8'd77, 32'h0);
        send_request(KIND_REMOVE, 8'd255, 32'hFFFF_FFFF);
        // Fill to capacity, then overflow
        for (int n = 0; n < QUEUE_DEPTH; n++) begin
            send_request(KIND_APPEND, ID_W'(n * 17), $urandom);
        end
        send_request(KIND_APPEND, 8'd1, 32'hDEAD_BEEF);
        // Remove the tail of a full queue, then a middle entry
        send_request(KIND_REMOVE, ID_W'((QUEUE_DEPTH - 1) * 17), 32'h0);
        send_request(KIND_REMOVE, ID_W'(7 * 17), 32'h0);

        // Sender idles often
        random_phase(PHASE_ITEMS / 2);
        wait_drained();
        random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
        wait_drained();
        // Sender idles most of the time
        sender_idle_pct = 82;
        random_phase(PHASE_ITEMS);
        wait_drained();
        // Back to back
        sender_idle_pct = 0;
        random_phase(PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb_ordered_queue_remove_by_id_unit: clean");
        end else begin
            $display("tb_ordered_queue_remove_by_id_unit: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("tb_ordered_queue_remove_by_id_unit: errors");
        $finish;
    end

endmodule
